// ===== hw/rtl/lbp_pkg.sv =====
// Shared types, constants and the code function of the 3x3 LBP operator.
// Depends on nothing; lbp_col_cell and lbp_image_operator import it.
`default_nettype none

package lbp_pkg;

  // Line buffer depth and the span of the 11-bit position counters
  localparam int MAX_WIDTH  = 2048;
  localparam int COUNT_SPAN = 2048;
  localparam int LINE_AW    = $clog2(MAX_WIDTH);

  // Widest usable row: the smaller of the buffer depth and the counter span
  localparam logic [11:0] WIDTH_CAP =
    12'((MAX_WIDTH < COUNT_SPAN) ? MAX_WIDTH : COUNT_SPAN);
  localparam logic [11:0] HEIGHT_CAP = 12'(COUNT_SPAN);

  // Configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [11:0] HEIGHT_RESET = 12'd480;

  typedef logic [7:0] pixel_t;

  // One window column: top, middle and bottom pixel
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

  // LBP code of the centre of a 3x3 window given as three columns
  function automatic logic [7:0] lbp_code_of(col_t left, col_t centre, col_t right);
    logic [7:0] code;
    pixel_t     c;
    c       = centre.mid;
    code[7] = left.mid   >= c;
    code[6] = left.top   >= c;
    code[5] = centre.top >= c;
    code[4] = right.top  >= c;
    code[3] = right.mid  >= c;
    code[2] = right.bot  >= c;
    code[1] = centre.bot >= c;
    code[0] = left.bot   >= c;
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lbp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Read-first: a read and a write to the same address return the old word.
`default_nettype none

module lbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_col_cell.sv =====
// One column cell of the sliding 3x3 window; cells are chained right to left.
// Depends on lbp_pkg for the column type.
`default_nettype none

module lbp_col_cell
  import lbp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic shift_en,
  input  wire col_t col_in,
  output col_t      col_out
);

  col_t col;

  // Take the neighbor's column on every window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift_en) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_image_operator.sv =====
// 3x3 local binary pattern operator on a raster-order 8-bit pixel stream.
// Pipeline: an accepted pixel is registered in stage 1, then its result in the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the single line-buffer RAM port pair.
// Reset: position counters, window cells and pipeline valids clear at once;
// frame_width and frame_height return to 640 and 480. Line buffers are not
// cleared, so the first pixel can be taken in the cycle after reset.
// Depends on lbp_pkg, lbp_ram and lbp_col_cell.
`default_nettype none

module lbp_image_operator
  import lbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data,
  // pixel input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pixel_value,
  input  wire logic        frame_start,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       lbp_code,
  output logic [10:0]      center_row,
  output logic [10:0]      center_col,
  output logic             last_code
);

  // Configuration registers
  logic [11:0] frame_width;
  logic [11:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the usable range
  logic [11:0] w_eff;
  logic [11:0] h_eff;

  always_comb begin
    w_eff = frame_width;
    if (w_eff == 12'd0) w_eff = 12'd1;
    if (w_eff > WIDTH_CAP) w_eff = WIDTH_CAP;
    h_eff = frame_height;
    if (h_eff == 12'd0) h_eff = 12'd1;
    if (h_eff > HEIGHT_CAP) h_eff = HEIGHT_CAP;
  end

  // Position of the next pixel
  logic [10:0] row_cnt;
  logic [10:0] col_cnt;
  logic [10:0] row_cnt_next;
  logic [10:0] col_cnt_next;

  logic        in_xfer;
  logic [10:0] r_cur;
  logic [10:0] c_cur;
  logic        emit_cur;
  logic        last_cur;

  assign in_xfer = in_valid && in_ready;

  // Wrap the stored position for the current size, then step past this pixel
  always_comb begin
    logic        c_wrap;
    logic [11:0] r_inc;
    logic [11:0] c_step;
    logic        c_wrap2;
    logic [11:0] r_step;
    c_wrap = 1'b0;
    r_inc  = '0;
    if (frame_start) begin
      r_cur = '0;
      c_cur = '0;
    end else begin
      c_wrap = {1'b0, col_cnt} >= w_eff;
      r_inc  = {1'b0, row_cnt} + {11'd0, c_wrap};
      r_cur  = (r_inc >= h_eff) ? 11'd0 : r_inc[10:0];
      c_cur  = c_wrap ? 11'd0 : col_cnt;
    end
    c_step       = {1'b0, c_cur} + 12'd1;
    c_wrap2      = c_step >= w_eff;
    r_step       = {1'b0, r_cur} + {11'd0, c_wrap2};
    row_cnt_next = (r_step >= h_eff) ? 11'd0 : r_step[10:0];
    col_cnt_next = c_wrap2 ? 11'd0 : c_step[10:0];
    emit_cur     = (r_cur >= 11'd2) && (c_cur >= 11'd2);
    last_cur     = ({1'b0, r_cur} == h_eff - 12'd1) && ({1'b0, c_cur} == w_eff - 12'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (in_xfer) begin
      row_cnt <= row_cnt_next;
      col_cnt <= col_cnt_next;
    end
  end

  // Pipeline control: stage 1 leaves when the output register is free
  logic s1_valid;
  logic out_free;
  logic s1_adv;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Line buffers: upper line in the high byte, middle line in the low byte
  logic [LINE_AW-1:0] rd_addr;
  logic [LINE_AW-1:0] s1_addr;
  logic [15:0]        line_rdata;
  logic [15:0]        line_wdata;

  assign rd_addr = LINE_AW'(c_cur);

  lbp_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (line_wdata),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (line_rdata)
  );

  // Stage 1 payload
  pixel_t      s1_pix;
  logic [10:0] s1_row;
  logic [10:0] s1_col;
  logic        s1_emit;
  logic        s1_last;
  logic        s1_fwd;
  logic [15:0] s1_fwd_data;
  logic [15:0] s1_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the pixel; forward a same-column write that lands with the read
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix      <= pixel_value;
      s1_addr     <= rd_addr;
      s1_row      <= r_cur - 11'd1;
      s1_col      <= c_cur - 11'd1;
      s1_emit     <= emit_cur;
      s1_last     <= last_cur;
      s1_fwd      <= s1_adv && (s1_addr == rd_addr);
      s1_fwd_data <= line_wdata;
    end
  end

  assign s1_line    = s1_fwd ? s1_fwd_data : line_rdata;
  assign line_wdata = {s1_line[7:0], s1_pix};

  // Window: chain of two column cells, fed from the right; the new column is the third
  col_t col_new;
  col_t col_right;
  col_t col_mid;

  assign col_new = '{top: s1_line[15:8], mid: s1_line[7:0], bot: s1_pix};

  lbp_col_cell u_cell_right (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_adv),
    .col_in   (col_new),
    .col_out  (col_right)
  );

  lbp_col_cell u_cell_mid (
    .clk      (clk),
    .rst      (rst),
    .shift_en (s1_adv),
    .col_in   (col_right),
    .col_out  (col_mid)
  );

  // The window after this shift is (mid cell, right cell, new column)
  logic [7:0] code_next;
  assign code_next = lbp_code_of(col_mid, col_right, col_new);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      lbp_code   <= code_next;
      center_row <= s1_row;
      center_col <= s1_col;
      last_code  <= s1_last;
    end
  end

`ifndef SYNTHESIS
  // An interior pixel leaving stage 1 always shows a result next cycle
  assert property (@(posedge clk) disable iff (rst) s1_adv && s1_emit |=> out_valid)
    else $error("interior pixel produced no result");

  // A transferred pixel occupies stage 1 in the next cycle
  assert property (@(posedge clk) disable iff (rst) in_xfer |=> s1_valid)
    else $error("accepted pixel lost before stage 1");

  // Results only name interior positions
  assert property (@(posedge clk) disable iff (rst)
                   out_valid |-> (center_row >= 11'd1) && (center_col >= 11'd1))
    else $error("result names a border pixel");

  // Stage 1 never leaves while the output register holds an untaken result
  assert property (@(posedge clk) disable iff (rst)
                   out_valid && !out_ready |-> !s1_adv)
    else $error("stage 1 advanced over a stalled result");
`endif

endmodule

`default_nettype wire
